[sv/pdct_pkg.sv]
// Package for the Poisson-disk candidate test core.
// Holds field widths, default parameters, register and status codes and shared structs.
// No dependencies.
`default_nettype none

package pdct_pkg;

	// Payload widths fixed by the channel format
	localparam int CAND_W   = 16;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 10;
	localparam int COUNT_W  = 11;

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Defaults for top-level parameters
	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 16;

	// Register reset values
	localparam logic [CAND_W-1:0]  AREA_WIDTH_RST  = 16'hFFFF;
	localparam logic [CAND_W-1:0]  AREA_HEIGHT_RST = 16'hFFFF;
	localparam logic [CAND_W-1:0]  MIN_DIST_RST    = 16'd160;
	localparam logic [COUNT_W-1:0] POINT_LIMIT_RST = 11'd1024;

	// Register indexes (byte address 4*i)
	typedef enum logic [1:0] {
		REG_AREA_WIDTH  = 2'd0,
		REG_AREA_HEIGHT = 2'd1,
		REG_MIN_DIST    = 2'd2,
		REG_POINT_LIMIT = 2'd3
	} pdct_reg_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_ACCEPT = 2'd0,
		STATUS_OOB    = 2'd1,
		STATUS_CLOSE  = 2'd2,
		STATUS_FULL   = 2'd3
	} pdct_status_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} pdct_state_t;

	// Configuration register set
	typedef struct packed {
		logic [CAND_W-1:0]  area_width;
		logic [CAND_W-1:0]  area_height;
		logic [CAND_W-1:0]  min_dist;
		logic [COUNT_W-1:0] point_limit;
	} pdct_cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_cand;
		logic start_scan;
		logic rd_en;
		logic commit;
	} pdct_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic oob;
		logic cnt_zero;
		logic last_rd;
		logic pipe_busy;
	} pdct_stat_t;

endpackage

`default_nettype wire

[sv/pdct_if.sv]
// Channel interfaces for the Poisson-disk candidate test core.
// Candidate and result channels with valid/ready handshake; depends on pdct_pkg.
`default_nettype none

interface pdct_cand_if import pdct_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CAND_W-1:0] cand_x;
	logic [CAND_W-1:0] cand_y;

	modport source (output valid, cand_x, cand_y, input ready);
	modport sink   (input valid, cand_x, cand_y, output ready);
endinterface

interface pdct_res_if import pdct_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  point_index;
	logic [COUNT_W-1:0]  point_count;

	modport source (output valid, status, point_index, point_count, input ready);
	modport sink   (input valid, status, point_index, point_count, output ready);
endinterface

`default_nettype wire

[sv/pdct_regs.sv]
// APB-style configuration registers for the Poisson-disk candidate test core.
// Depends on pdct_pkg for register codes, widths and reset values.
`default_nettype none

module pdct_regs import pdct_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output pdct_cfg_t               cfg
);

	pdct_cfg_t cfg_q;
	logic      wr_en;
	pdct_reg_t reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = pdct_reg_t'(paddr[3:2]);
	assign cfg     = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.area_width  <= AREA_WIDTH_RST;
			cfg_q.area_height <= AREA_HEIGHT_RST;
			cfg_q.min_dist    <= MIN_DIST_RST;
			cfg_q.point_limit <= POINT_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_AREA_WIDTH:  cfg_q.area_width  <= pwdata[CAND_W-1:0];
				REG_AREA_HEIGHT: cfg_q.area_height <= pwdata[CAND_W-1:0];
				REG_MIN_DIST:    cfg_q.min_dist    <= pwdata[CAND_W-1:0];
				REG_POINT_LIMIT: cfg_q.point_limit <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_sel)
			REG_AREA_WIDTH:  prdata = PDATA_W'(cfg_q.area_width);
			REG_AREA_HEIGHT: prdata = PDATA_W'(cfg_q.area_height);
			REG_MIN_DIST:    prdata = PDATA_W'(cfg_q.min_dist);
			REG_POINT_LIMIT: prdata = PDATA_W'(cfg_q.point_limit);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[sv/pdct_ctrl.sv]
// Controller state machine for the Poisson-disk candidate test core.
// Sequences candidate capture, store scan, pipeline drain and result commit; uses pdct_pkg.
`default_nettype none

module pdct_ctrl import pdct_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cand_valid,
	output logic            cand_ready,
	output logic            res_valid,
	input  wire logic       res_ready,
	input  wire pdct_stat_t stat,
	output pdct_cmd_t       cmd
);

	pdct_state_t state_q, state_nx;
	logic        res_valid_q;
	logic        slot_free;

	// Output slot is free when empty or being emptied this cycle
	assign slot_free = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (cand_valid) state_nx = ST_CHECK;
			ST_CHECK:  state_nx = (stat.oob || stat.cnt_zero) ? ST_DECIDE : ST_SCAN;
			ST_SCAN:   if (stat.last_rd) state_nx = ST_DRAIN;
			ST_DRAIN:  if (!stat.pipe_busy) state_nx = ST_DECIDE;
			ST_DECIDE: if (slot_free) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cand_ready     = 1'b0;
		cmd.load_cand  = 1'b0;
		cmd.start_scan = 1'b0;
		cmd.rd_en      = 1'b0;
		cmd.commit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cand_ready    = 1'b1;
				cmd.load_cand = cand_valid;
			end
			ST_CHECK:  cmd.start_scan = 1'b1;
			ST_SCAN:   cmd.rd_en      = 1'b1;
			ST_DRAIN:  ;
			ST_DECIDE: cmd.commit     = slot_free;
			default:   ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Hold the result valid until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[sv/pdct_dpath.sv]
// Datapath for the Poisson-disk candidate test core.
// Point store memory, squared-distance pipeline, point count and result register; uses pdct_pkg.
`default_nettype none

module pdct_dpath import pdct_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pdct_cmd_t           cmd,
	output pdct_stat_t               stat,
	input  wire pdct_cfg_t           cfg,
	input  wire logic [CAND_W-1:0]   cand_x,
	input  wire logic [CAND_W-1:0]   cand_y,
	output logic      [STATUS_W-1:0] status,
	output logic      [INDEX_W-1:0]  point_index,
	output logic      [COUNT_W-1:0]  point_count
);

	localparam int CW    = (COORD_BITS < CAND_W) ? COORD_BITS : CAND_W;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int LW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int SQ_W  = 2 * CW;
	localparam int LIM_W = 2 * CAND_W;
	localparam int DW    = ((SQ_W + 1) > (LIM_W + 1)) ? (SQ_W + 1) : (LIM_W + 1);

	logic [2*CW-1:0]    mem [MAX_POINTS];
	logic [CW-1:0]      cx_q, cy_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   rd_addr_q;
	logic [2*CW-1:0]    rdata_s1;
	logic               v_s1, v_s2;
	logic [SQ_W-1:0]    sqx_s2, sqy_s2;
	logic               hit_q;
	logic [LIM_W-1:0]   lim_q;
	logic [CW-1:0]      rx, ry, dx, dy;
	logic [DW-1:0]      dist2;
	logic               near;
	logic               oob;
	logic               full;
	logic [LW-1:0]      cnt_l;
	logic [LW-1:0]      cnt_nx_l;
	logic [CNT_W-1:0]   cnt_nx;
	pdct_status_t       st;
	logic [STATUS_W-1:0] res_status_q;
	logic [INDEX_W-1:0]  res_index_q;
	logic [COUNT_W-1:0]  res_count_q;

	// Capture the candidate, keeping the coordinate bits in use
	always_ff @(posedge clk) begin
		if (cmd.load_cand) begin
			cx_q <= cand_x[CW-1:0];
			cy_q <= cand_y[CW-1:0];
		end
	end

	// Squared minimum distance, refreshed every cycle from the register
	always_ff @(posedge clk) begin
		lim_q <= LIM_W'(cfg.min_dist) * LIM_W'(cfg.min_dist);
	end

	// Bounds and fill checks
	assign oob      = (CAND_W'(cx_q) > cfg.area_width) || (CAND_W'(cy_q) > cfg.area_height);
	assign cnt_l    = LW'(count_q);
	assign full     = (cnt_l >= LW'(cfg.point_limit)) || (cnt_l >= LW'(MAX_POINTS));

	assign stat.oob       = oob;
	assign stat.cnt_zero  = (count_q == '0);
	assign stat.last_rd   = ((CNT_W'(rd_addr_q) + CNT_W'(1)) == count_q);
	assign stat.pipe_busy = v_s1 || v_s2;

	// Read one stored point per cycle
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[rd_addr_q];
	end

	// Append an accepted point
	always_ff @(posedge clk) begin
		if (cmd.commit && (st == STATUS_ACCEPT)) begin
			mem[count_q[IDX_W-1:0]] <= {cx_q, cy_q};
		end
	end

	// Scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
		end else if (cmd.start_scan) begin
			rd_addr_q <= '0;
		end else if (cmd.rd_en) begin
			rd_addr_q <= rd_addr_q + IDX_W'(1);
		end
	end

	// Absolute differences against the stored point
	assign rx = rdata_s1[2*CW-1:CW];
	assign ry = rdata_s1[CW-1:0];
	assign dx = (cx_q >= rx) ? (cx_q - rx) : (rx - cx_q);
	assign dy = (cy_q >= ry) ? (cy_q - ry) : (ry - cy_q);

	// Square both differences
	always_ff @(posedge clk) begin
		sqx_s2 <= SQ_W'(dx) * SQ_W'(dx);
		sqy_s2 <= SQ_W'(dy) * SQ_W'(dy);
	end

	assign dist2 = DW'(sqx_s2) + DW'(sqy_s2);
	assign near  = dist2 < DW'(lim_q);

	// Pipeline valids and sticky too-close flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			if (cmd.load_cand) begin
				hit_q <= 1'b0;
			end else if (v_s2 && near) begin
				hit_q <= 1'b1;
			end
		end
	end

	// Decide the outcome: bounds first, then spacing, then fill
	always_comb begin
		if (oob) begin
			st = STATUS_OOB;
		end else if (hit_q) begin
			st = STATUS_CLOSE;
		end else if (full) begin
			st = STATUS_FULL;
		end else begin
			st = STATUS_ACCEPT;
		end
	end

	assign cnt_nx   = (st == STATUS_ACCEPT) ? (count_q + CNT_W'(1)) : count_q;
	assign cnt_nx_l = LW'(cnt_nx);

	// Point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= cnt_nx;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_status_q <= st;
			res_index_q  <= (st == STATUS_ACCEPT) ? cnt_l[INDEX_W-1:0] : '0;
			res_count_q  <= cnt_nx_l[COUNT_W-1:0];
		end
	end

	assign status      = res_status_q;
	assign point_index = res_index_q;
	assign point_count = res_count_q;

endmodule

`default_nettype wire

[sv/poisson_disk_candidate_test_core.sv]
// Poisson-disk candidate test core: tests a candidate against the stored points.
// Sequence: candidate transfer, check, scan of the N stored points, pipeline drain, decide and commit;
// the scan and drain are skipped when the candidate is out of bounds or the store is empty.
// A new candidate is taken only after the last result is committed; one store read a cycle in the scan.
// Reset: arst_n clears the point count, registers to defaults and the controller; store is not cleared.
// Depends on pdct_pkg, pdct_if, pdct_regs, pdct_ctrl and pdct_dpath.
`default_nettype none

module poisson_disk_candidate_test_core import pdct_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	pdct_cand_if.sink               cand,
	pdct_res_if.source              res
);

	pdct_cfg_t  cfg;
	pdct_cmd_t  cmd;
	pdct_stat_t stat;

	// Configuration registers
	pdct_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer
	pdct_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand.valid),
		.cand_ready (cand.ready),
		.res_valid  (res.valid),
		.res_ready  (res.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Store, distance pipeline and result register
	pdct_dpath #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg         (cfg),
		.cand_x      (cand.cand_x),
		.cand_y      (cand.cand_y),
		.status      (res.status),
		.point_index (res.point_index),
		.point_count (res.point_count)
	);

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for poisson_disk_candidate_test_core: candidates are driven over the
// input channel and each result is checked against a behavioural copy of the point store.
// Depends on pdct_pkg, pdct_if and the core itself.

module tb_top;
	import pdct_pkg::*;

	localparam int HALF_PERIOD     = 2;
	localparam int MAX_POINTS      = MAX_POINTS_DEF;
	localparam int GAP_MAX         = 14;
	localparam int HOLD_CYCLES     = 3000;
	localparam int DRAIN_CYCLES    = MAX_POINTS + 64;
	localparam int LIMIT_CYCLES    = 3_000_000;
	localparam int RAND_PHASES     = 6;
	localparam int ITEMS_PER_PHASE = 97;
	localparam int MAX_REPORTS     = 40;
	localparam logic [CAND_W-1:0] COORD_MAX = '1;

	typedef struct packed {
		logic [CAND_W-1:0] x;
		logic [CAND_W-1:0] y;
	} cand_item_t;

	typedef struct packed {
		pdct_status_t       status;
		logic [INDEX_W-1:0] index;
		logic [COUNT_W-1:0] count;
	} verdict_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	pdct_cand_if cand ();
	pdct_res_if  res ();

	poisson_disk_candidate_test_core #(
		.MAX_POINTS(MAX_POINTS_DEF),
		.COORD_BITS(COORD_BITS_DEF)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cand   (cand),
		.res    (res)
	);

	always #HALF_PERIOD clk = ~clk;

	// Behavioural copy of the registers and the point store
	logic [CAND_W-1:0]  cfg_width;
	logic [CAND_W-1:0]  cfg_height;
	logic [CAND_W-1:0]  cfg_min;
	logic [COUNT_W-1:0] cfg_limit;
	logic [CAND_W-1:0]  kept_x [MAX_POINTS];
	logic [CAND_W-1:0]  kept_y [MAX_POINTS];
	int                 kept_count;

	cand_item_t cand_q[$];
	cand_item_t hist_q[$];
	verdict_t   verdict_q[$];

	int gap_max;
	int stall_max;
	int gap_left;
	int stall_left;
	int hold_left;
	int hold_reqs;
	int holds_taken;
	int fail_count = 0;
	int settings_used = 0;
	int cycle_count = 0;
	int status_tally[4] = '{default: 0};

	function automatic void log_fail(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endfunction

	// Bounds first, then spacing against every stored point, then room in the store
	function automatic verdict_t judge_candidate(input logic [CAND_W-1:0] x,
			input logic [CAND_W-1:0] y);
		verdict_t   v;
		logic [63:0] lim;
		logic [63:0] dx;
		logic [63:0] dy;
		int          eff_limit;
		bit          close;
		v.index = '0;
		close = 1'b0;
		lim = 64'(cfg_min) * 64'(cfg_min);
		eff_limit = (cfg_limit > MAX_POINTS) ? MAX_POINTS : int'(cfg_limit);
		if (x > cfg_width || y > cfg_height) begin
			v.status = STATUS_OOB;
		end else begin
			for (int i = 0; i < kept_count; i++) begin
				dx = (x >= kept_x[i]) ? 64'(x) - 64'(kept_x[i]) : 64'(kept_x[i]) - 64'(x);
				dy = (y >= kept_y[i]) ? 64'(y) - 64'(kept_y[i]) : 64'(kept_y[i]) - 64'(y);
				if (dx * dx + dy * dy < lim)
					close = 1'b1;
			end
			if (close) begin
				v.status = STATUS_CLOSE;
			end else if (kept_count >= eff_limit) begin
				v.status = STATUS_FULL;
			end else begin
				v.status = STATUS_ACCEPT;
				v.index = INDEX_W'(kept_count);
				kept_x[kept_count] = x;
				kept_y[kept_count] = y;
				kept_count++;
			end
		end
		v.count = COUNT_W'(kept_count);
		return v;
	endfunction

	function automatic logic [CAND_W-1:0] clamp_coord(input int v);
		if (v < 0)
			return '0;
		if (v > int'(COORD_MAX))
			return COORD_MAX;
		return CAND_W'(v);
	endfunction

	// Mix of in-area darts, near misses around earlier points, repeats and strays
	function automatic cand_item_t make_candidate();
		cand_item_t c;
		cand_item_t base;
		int         mode;
		int         reach;
		int         off_x;
		int         off_y;
		mode = $urandom_range(0, 99);
		if (hist_q.size() == 0 || mode < 45) begin
			c.x = CAND_W'($urandom_range(0, int'(cfg_width)));
			c.y = CAND_W'($urandom_range(0, int'(cfg_height)));
		end else if (mode < 70) begin
			base = hist_q[$urandom_range(0, hist_q.size() - 1)];
			reach = (cfg_min == 0) ? 8 : ((cfg_min > 4000) ? 4000 : int'(cfg_min));
			off_x = $urandom_range(0, reach + reach / 4);
			off_y = $urandom_range(0, reach + reach / 4);
			if ($urandom_range(0, 1))
				off_x = -off_x;
			if ($urandom_range(0, 1))
				off_y = -off_y;
			c.x = clamp_coord(int'(base.x) + off_x);
			c.y = clamp_coord(int'(base.y) + off_y);
		end else if (mode < 80) begin
			c = hist_q[$urandom_range(0, hist_q.size() - 1)];
		end else if (mode < 90 && cfg_width < COORD_MAX && $urandom_range(0, 1)) begin
			c.x = CAND_W'($urandom_range(int'(cfg_width) + 1, int'(COORD_MAX)));
			c.y = CAND_W'($urandom());
		end else if (mode < 90 && cfg_height < COORD_MAX) begin
			c.x = CAND_W'($urandom());
			c.y = CAND_W'($urandom_range(int'(cfg_height) + 1, int'(COORD_MAX)));
		end else begin
			c.x = CAND_W'($urandom());
			c.y = CAND_W'($urandom());
		end
		hist_q = {hist_q, c};
		return c;
	endfunction

	// Candidate driver: hold until transfer, then wait the drawn gap before the next one
	always @(posedge clk or negedge arst_n) begin
		cand_item_t item;
		if (!arst_n) begin
			cand.valid  <= 1'b0;
			cand.cand_x <= '0;
			cand.cand_y <= '0;
			gap_left    <= 0;
		end else if (!cand.valid || cand.ready) begin
			if (gap_left != 0) begin
				cand.valid <= 1'b0;
				gap_left   <= gap_left - 1;
			end else if (cand_q.size() != 0) begin
				item = cand_q.pop_front();
				cand.valid  <= 1'b1;
				cand.cand_x <= item.x;
				cand.cand_y <= item.y;
				gap_left    <= $urandom_range(0, gap_max);
			end else begin
				cand.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stall per transfer, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		int n;
		if (!arst_n) begin
			res.ready   <= 1'b0;
			stall_left  <= 0;
			hold_left   <= 0;
			holds_taken <= 0;
		end else if (holds_taken != hold_reqs) begin
			holds_taken <= holds_taken + 1;
			hold_left   <= HOLD_CYCLES;
			res.ready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res.ready <= 1'b0;
		end else if (res.valid && res.ready) begin
			n = $urandom_range(0, stall_max);
			stall_left <= n;
			res.ready  <= (n == 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res.ready  <= (stall_left == 1);
		end else begin
			res.ready <= 1'b1;
		end
	end

	// Predict on each candidate transfer, check each result transfer against the oldest verdict
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n) begin
			if (cand.valid && cand.ready)
				verdict_q = {verdict_q, judge_candidate(cand.cand_x, cand.cand_y)};
			if (res.valid && res.ready) begin
				if (verdict_q.size() == 0) begin
					log_fail($sformatf("unexpected result: status %0d index %0d count %0d",
						res.status, res.point_index, res.point_count));
				end else begin
					want = verdict_q.pop_front();
					status_tally[want.status]++;
					if (res.status !== want.status)
						log_fail($sformatf("status: expected %0d, got %0d",
							want.status, res.status));
					if (res.point_index !== want.index)
						log_fail($sformatf("point_index: expected %0d, got %0d",
							want.index, res.point_index));
					if (res.point_count !== want.count)
						log_fail($sformatf("point_count: expected %0d, got %0d",
							want.count, res.point_count));
				end
			end
		end
	end

	// Guard against a hang
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Run stopped after %0d cycles with %0d results outstanding",
				cycle_count, verdict_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Wait until every candidate is through and every verdict has been matched
	task automatic settle();
		do
			@(negedge clk);
		while (cand_q.size() != 0 || cand.valid || verdict_q.size() != 0);
	endtask

	// Write one register, then read it back
	task automatic write_reg(input pdct_reg_t idx, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] kept;
		kept = (idx == REG_POINT_LIMIT) ? (value & 32'h7FF) : (value & 32'hFFFF);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		@(posedge clk);
		case (idx)
			REG_AREA_WIDTH:  cfg_width  = kept[CAND_W-1:0];
			REG_AREA_HEIGHT: cfg_height = kept[CAND_W-1:0];
			REG_MIN_DIST:    cfg_min    = kept[CAND_W-1:0];
			REG_POINT_LIMIT: cfg_limit  = kept[COUNT_W-1:0];
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		if (prdata !== kept)
			log_fail($sformatf("register %s read back: expected %0d, got %0d",
				idx.name(), kept, prdata));
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input int w, input int h, input int md, input int lim);
		settle();
		write_reg(REG_AREA_WIDTH, w);
		write_reg(REG_AREA_HEIGHT, h);
		write_reg(REG_MIN_DIST, md);
		write_reg(REG_POINT_LIMIT, lim);
		settings_used++;
	endtask

	task automatic offer(input int x, input int y);
		cand_item_t c;
		c.x = CAND_W'(x);
		c.y = CAND_W'(y);
		cand_q = {cand_q, c};
		hist_q = {hist_q, c};
	endtask

	function automatic int pick_area();
		case ($urandom_range(0, 3))
			0:       return int'(COORD_MAX);
			1:       return $urandom_range(1, 4095);
			default: return $urandom_range(0, int'(COORD_MAX));
		endcase
	endfunction

	function automatic int pick_spacing();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return int'(COORD_MAX);
			2, 3:    return $urandom_range(1, 400);
			default: return $urandom_range(400, 6000);
		endcase
	endfunction

	initial begin
		int w;
		int h;
		int md;
		int lim;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		cand.valid  = 1'b0;
		cand.cand_x = '0;
		cand.cand_y = '0;
		res.ready   = 1'b0;
		arst_n      = 1'b0;
		gap_max     = GAP_MAX;
		stall_max   = GAP_MAX;
		hold_reqs   = 0;
		cfg_width   = AREA_WIDTH_RST;
		cfg_height  = AREA_HEIGHT_RST;
		cfg_min     = MIN_DIST_RST;
		cfg_limit   = POINT_LIMIT_RST;
		kept_count  = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: empty store, repeat point, far corner, spacing exactly at the minimum
		offer(0, 0);
		offer(0, 0);
		offer(int'(COORD_MAX), int'(COORD_MAX));
		offer(160, 0);
		offer(159, 0);
		offer(1000, 1000);

		// Inclusive bounds, zero spacing lets duplicates in, limit reached, bounds beat full
		set_config(1000, 2000, 0, 6);
		offer(1001, 5);
		offer(5, 2001);
		offer(1000, 2000);
		offer(1000, 1000);
		offer(500, 500);
		offer(1001, 0);

		// Limit dropped below the count; spacing refusal still wins over full
		set_config(1000, 2000, int'(COORD_MAX), 0);
		offer(0, 0);
		offer(999, 1999);

		// Degenerate one-point area
		set_config(0, 0, 0, 0);
		offer(0, 0);
		offer(1, 0);
		offer(0, 1);

		// Widest spacing, limit above the store size
		set_config(int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX), 1500);
		offer(32768, 32768);
		offer(int'(COORD_MAX), 0);
		offer(0, int'(COORD_MAX));

		// Random phases, each under its own register setting and idling pattern
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					w = int'(COORD_MAX); h = int'(COORD_MAX); md = 160;
					lim = kept_count + 40;
					gap_max = GAP_MAX; stall_max = GAP_MAX;
				end
				1: begin
					w = pick_area(); h = pick_area(); md = $urandom_range(1, 400);
					lim = MAX_POINTS;
					gap_max = 0; stall_max = GAP_MAX;
				end
				2: begin
					w = pick_area(); h = pick_area(); md = 0;
					lim = kept_count + 25;
					gap_max = 0; stall_max = 0;
				end
				3: begin
					w = pick_area(); h = pick_area(); md = pick_spacing();
					lim = 2047;
					gap_max = GAP_MAX; stall_max = 0;
				end
				4: begin
					w = int'(COORD_MAX); h = int'(COORD_MAX); md = int'(COORD_MAX);
					lim = kept_count;
					gap_max = GAP_MAX; stall_max = GAP_MAX;
				end
				default: begin
					w = pick_area(); h = pick_area(); md = pick_spacing();
					lim = $urandom_range(0, MAX_POINTS);
					gap_max = GAP_MAX; stall_max = GAP_MAX;
				end
			endcase
			set_config(w, h, md, lim);
			// Starve the result side while the sender keeps pushing
			if (ph == 1)
				hold_reqs++;
			repeat (ITEMS_PER_PHASE)
				cand_q = {cand_q, make_candidate()};
		end

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d candidates under %0d register settings: %0d accepted, %0d out of area,",
			hist_q.size(), settings_used + 1, status_tally[STATUS_ACCEPT],
			status_tally[STATUS_OOB]);
		$display("%0d too close, %0d refused with the store full; %0d points stored at the end.",
			status_tally[STATUS_CLOSE], status_tally[STATUS_FULL], kept_count);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
sv/pdct_pkg.sv
sv/pdct_if.sv
sv/pdct_regs.sv
sv/pdct_ctrl.sv
sv/pdct_dpath.sv
sv/poisson_disk_candidate_test_core.sv
tb/tb_top.sv
